### rtl/smci_pkg.sv
// shared types, constants and helper functions for the motor command interlock
package smci_pkg;

    localparam int LINE_MAX  = 64;
    localparam int CNT_W     = $clog2(LINE_MAX);
    localparam int MAG_W     = 7;
    localparam int FS_W      = 15;
    localparam int PROD_W    = MAG_W + FS_W;
    localparam int DUTY_W    = 16;
    localparam int SW_W      = 4;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_MAX - 1);
    localparam logic [MAG_W-1:0] MAG_SAT   = MAG_W'(101);
    localparam logic [MAG_W-1:0] MAG_MAX   = MAG_W'(100);
    localparam logic [FS_W-1:0]  FS_RESET  = FS_W'(4199);

    // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^PROD_W
    localparam int               RECIP_SHIFT = 29;
    localparam int               RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
    localparam int               SCALED_W    = PROD_W + RECIP_W;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int          APB_AW             = 3;
    localparam logic        REG_FULL_SCALE_SEL = 1'b0;

    typedef enum logic [3:0] {
        PH_PRE0   = 4'd0,
        PH_PRE1   = 4'd1,
        PH_PRE2   = 4'd2,
        PH_PRE3   = 4'd3,
        PH_PRE4   = 4'd4,
        PH_A_WS   = 4'd5,
        PH_A_SIGN = 4'd6,
        PH_A_DIG  = 4'd7,
        PH_B_WS   = 4'd8,
        PH_B_SIGN = 4'd9,
        PH_B_DIG  = 4'd10,
        PH_DONE   = 4'd11,
        PH_FAIL   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_APPLIED   = 2'd1,
        ST_REFUSED   = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_LOAD = 2'd1,
        OP_ZERO = 2'd2
    } drive_op_t;

    typedef struct packed {
        logic            action;
        logic [7:0]      rx_char;
        logic [SW_W-1:0] switch_bits;
    } in_t;

    typedef struct packed {
        logic signed [DUTY_W-1:0] drive_a;
        logic signed [DUTY_W-1:0] drive_b;
        logic [SW_W-1:0]          contact_bits;
        logic                     docked;
        logic [1:0]               line_status;
    } out_t;

    typedef struct packed {
        drive_op_t         op;
        status_t           status;
        logic [SW_W-1:0]   sw;
        logic              neg_a;
        logic              neg_b;
        logic [PROD_W-1:0] prod_a;
        logic [PROD_W-1:0] prod_b;
    } parse_evt_t;

    typedef struct packed {
        drive_op_t       op;
        status_t         status;
        logic [SW_W-1:0] sw;
        logic            neg_a;
        logic            neg_b;
        logic [FS_W-1:0] duty_a;
        logic [FS_W-1:0] duty_b;
    } scale_evt_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h4D;
            3'd3:    ch = 8'h44;
            default: ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // saturating decimal accumulation
    function automatic logic [MAG_W-1:0] mag_add(input logic [MAG_W-1:0] m,
                                                 input logic [7:0] c);
        logic [10:0] v;
        v = ({4'b0, m} * 11'd10) + {3'b0, (c - CH_ZERO)};
        return (v > {4'b0, MAG_SAT}) ? MAG_SAT : v[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag_clamp(input logic [MAG_W-1:0] m);
        return (m > MAG_MAX) ? MAG_MAX : m;
    endfunction

endpackage

### rtl/smci_parser.sv
// line parser: command state, switch state and duty products at line end
module smci_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  smci_pkg::in_t                item,
    input  logic [smci_pkg::FS_W-1:0]    full_scale,
    output smci_pkg::parse_evt_t         evt
);

    smci_pkg::phase_t                  phase_reg, phase_next;
    logic [smci_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [smci_pkg::MAG_W-1:0]        mag_a_reg, mag_a_next;
    logic [smci_pkg::MAG_W-1:0]        mag_b_reg, mag_b_next;
    logic                              neg_a_reg, neg_a_next;
    logic                              neg_b_reg, neg_b_next;
    logic [smci_pkg::SW_W-1:0]         switch_reg, switch_next;
    smci_pkg::parse_evt_t              evt_reg, evt_next;

    logic [7:0]                        c;
    logic                              sec;
    logic                              line_ok;

    assign c       = item.rx_char;
    assign sec     = (phase_reg == smci_pkg::PH_B_WS) || (phase_reg == smci_pkg::PH_B_SIGN);
    assign line_ok = (phase_reg == smci_pkg::PH_B_DIG) || (phase_reg == smci_pkg::PH_DONE);

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        neg_a_next  = neg_a_reg;
        neg_b_next  = neg_b_reg;
        switch_next = switch_reg;

        evt_next.op     = smci_pkg::OP_NONE;
        evt_next.status = smci_pkg::ST_NONE;
        evt_next.neg_a  = neg_a_reg;
        evt_next.neg_b  = neg_b_reg;
        evt_next.prod_a = smci_pkg::PROD_W'(smci_pkg::mag_clamp(mag_a_reg))
                          * smci_pkg::PROD_W'(full_scale);
        evt_next.prod_b = smci_pkg::PROD_W'(smci_pkg::mag_clamp(mag_b_reg))
                          * smci_pkg::PROD_W'(full_scale);

        if (item.action)
        begin
            switch_next = item.switch_bits;
            if (item.switch_bits != '0)
            begin
                evt_next.op = smci_pkg::OP_ZERO;
            end
        end
        else if (c == smci_pkg::CH_LF)
        begin
            if (!line_ok)
            begin
                evt_next.status = smci_pkg::ST_MALFORMED;
            end
            else if (switch_reg != '0)
            begin
                evt_next.status = smci_pkg::ST_REFUSED;
            end
            else
            begin
                evt_next.status = smci_pkg::ST_APPLIED;
                evt_next.op     = smci_pkg::OP_LOAD;
            end
            phase_next = smci_pkg::PH_PRE0;
            cnt_next   = '0;
            mag_a_next = '0;
            mag_b_next = '0;
            neg_a_next = 1'b0;
            neg_b_next = 1'b0;
        end
        else if ((c != smci_pkg::CH_CR) && (cnt_reg < smci_pkg::CNT_LIMIT))
        begin
            cnt_next = cnt_reg + 1'b1;
            if (c == smci_pkg::CH_NUL)
            begin
                // nul ends the parsable part of the line
                phase_next = line_ok ? smci_pkg::PH_DONE : smci_pkg::PH_FAIL;
            end
            else
            begin
                unique case (phase_reg)
                    smci_pkg::PH_PRE0, smci_pkg::PH_PRE1, smci_pkg::PH_PRE2,
                    smci_pkg::PH_PRE3, smci_pkg::PH_PRE4:
                    begin
                        if (c == smci_pkg::prefix_char(phase_reg[2:0]))
                        begin
                            phase_next = smci_pkg::phase_t'(phase_reg + 4'd1);
                        end
                        else
                        begin
                            phase_next = smci_pkg::PH_FAIL;
                        end
                    end
                    smci_pkg::PH_A_WS, smci_pkg::PH_B_WS:
                    begin
                        if (smci_pkg::is_ws(c))
                        begin
                            phase_next = phase_reg;
                        end
                        else if ((c == smci_pkg::CH_PLUS) || (c == smci_pkg::CH_MINUS))
                        begin
                            if (c == smci_pkg::CH_MINUS)
                            begin
                                if (sec)
                                begin
                                    neg_b_next = 1'b1;
                                end
                                else
                                begin
                                    neg_a_next = 1'b1;
                                end
                            end
                            phase_next = sec ? smci_pkg::PH_B_SIGN : smci_pkg::PH_A_SIGN;
                        end
                        else if (smci_pkg::is_digit(c))
                        begin
                            if (sec)
                            begin
                                mag_b_next = smci_pkg::mag_add('0, c);
                                phase_next = smci_pkg::PH_B_DIG;
                            end
                            else
                            begin
                                mag_a_next = smci_pkg::mag_add('0, c);
                                phase_next = smci_pkg::PH_A_DIG;
                            end
                        end
                        else
                        begin
                            phase_next = smci_pkg::PH_FAIL;
                        end
                    end
                    smci_pkg::PH_A_SIGN, smci_pkg::PH_B_SIGN:
                    begin
                        if (smci_pkg::is_digit(c))
                        begin
                            if (sec)
                            begin
                                mag_b_next = smci_pkg::mag_add('0, c);
                                phase_next = smci_pkg::PH_B_DIG;
                            end
                            else
                            begin
                                mag_a_next = smci_pkg::mag_add('0, c);
                                phase_next = smci_pkg::PH_A_DIG;
                            end
                        end
                        else
                        begin
                            phase_next = smci_pkg::PH_FAIL;
                        end
                    end
                    smci_pkg::PH_A_DIG:
                    begin
                        if (smci_pkg::is_digit(c))
                        begin
                            mag_a_next = smci_pkg::mag_add(mag_a_reg, c);
                        end
                        else if (c == smci_pkg::CH_COMMA)
                        begin
                            phase_next = smci_pkg::PH_B_WS;
                        end
                        else
                        begin
                            phase_next = smci_pkg::PH_FAIL;
                        end
                    end
                    smci_pkg::PH_B_DIG:
                    begin
                        if (smci_pkg::is_digit(c))
                        begin
                            mag_b_next = smci_pkg::mag_add(mag_b_reg, c);
                        end
                        else
                        begin
                            phase_next = smci_pkg::PH_DONE;
                        end
                    end
                    smci_pkg::PH_DONE:
                    begin
                        phase_next = smci_pkg::PH_DONE;
                    end
                    default:
                    begin
                        phase_next = smci_pkg::PH_FAIL;
                    end
                endcase
            end
        end

        evt_next.sw = switch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= smci_pkg::PH_PRE0;
            cnt_reg    <= '0;
            mag_a_reg  <= '0;
            mag_b_reg  <= '0;
            neg_a_reg  <= 1'b0;
            neg_b_reg  <= 1'b0;
            switch_reg <= '0;
        end
        else if (load)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            mag_a_reg  <= mag_a_next;
            mag_b_reg  <= mag_b_next;
            neg_a_reg  <= neg_a_next;
            neg_b_reg  <= neg_b_next;
            switch_reg <= switch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            evt_reg <= evt_next;
        end
    end

    assign evt = evt_reg;

endmodule

### rtl/smci_scale.sv
// divide the duty products by one hundred through a reciprocal multiply
module smci_scale (
    input  logic                   clk,
    input  logic                   load,
    input  smci_pkg::parse_evt_t   evt_in,
    output smci_pkg::scale_evt_t   evt_out
);

    smci_pkg::scale_evt_t                scale_reg, scale_next;
    logic [smci_pkg::SCALED_W-1:0]       scaled_a;
    logic [smci_pkg::SCALED_W-1:0]       scaled_b;

    assign scaled_a = smci_pkg::SCALED_W'(evt_in.prod_a) * smci_pkg::SCALED_W'(smci_pkg::RECIP_MUL);
    assign scaled_b = smci_pkg::SCALED_W'(evt_in.prod_b) * smci_pkg::SCALED_W'(smci_pkg::RECIP_MUL);

    always_comb
    begin
        scale_next.op     = evt_in.op;
        scale_next.status = evt_in.status;
        scale_next.sw     = evt_in.sw;
        scale_next.neg_a  = evt_in.neg_a;
        scale_next.neg_b  = evt_in.neg_b;
        scale_next.duty_a = scaled_a[smci_pkg::RECIP_SHIFT +: smci_pkg::FS_W];
        scale_next.duty_b = scaled_b[smci_pkg::RECIP_SHIFT +: smci_pkg::FS_W];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scale_reg <= scale_next;
        end
    end

    assign evt_out = scale_reg;

endmodule

### rtl/smci_drive.sv
// duty registers and result register
module smci_drive (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  smci_pkg::scale_evt_t   evt,
    output smci_pkg::out_t         result
);

    logic [smci_pkg::DUTY_W-1:0]   drive_a_reg, drive_a_next;
    logic [smci_pkg::DUTY_W-1:0]   drive_b_reg, drive_b_next;
    logic [smci_pkg::SW_W-1:0]     sw_reg;
    smci_pkg::status_t             status_reg;
    logic [smci_pkg::DUTY_W-1:0]   mag_a;
    logic [smci_pkg::DUTY_W-1:0]   mag_b;

    assign mag_a = {1'b0, evt.duty_a};
    assign mag_b = {1'b0, evt.duty_b};

    always_comb
    begin
        drive_a_next = drive_a_reg;
        drive_b_next = drive_b_reg;
        unique case (evt.op)
            smci_pkg::OP_LOAD:
            begin
                drive_a_next = evt.neg_a ? ('0 - mag_a) : mag_a;
                drive_b_next = evt.neg_b ? ('0 - mag_b) : mag_b;
            end
            smci_pkg::OP_ZERO:
            begin
                drive_a_next = '0;
                drive_b_next = '0;
            end
            default:
            begin
                drive_a_next = drive_a_reg;
                drive_b_next = drive_b_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_a_reg <= '0;
            drive_b_reg <= '0;
        end
        else if (load)
        begin
            drive_a_reg <= drive_a_next;
            drive_b_reg <= drive_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sw_reg     <= evt.sw;
            status_reg <= evt.status;
        end
    end

    always_comb
    begin
        result.drive_a      = drive_a_reg;
        result.drive_b      = drive_b_reg;
        result.contact_bits = sw_reg;
        result.docked       = (sw_reg != '0);
        result.line_status  = status_reg;
    end

endmodule

### rtl/serial_motor_command_interlock.sv
// top level of the serial motor command interlock
//
// in channel: one transaction per serial byte (action 0) or limit switch
// sample (action 1), taken when in_valid is high and in_stall is low.
// out channel: exactly one result transaction per input transaction, in
// order, with both signed arm duties, the switch state and the line status.
// one transaction per cycle is sustained while out_stall stays low. the path runs
// input register, parser (line state and duty products), reciprocal divide by
// one hundred, duty/result register.
// each stage holds its transaction while the next is full, so bubbles are
// squeezed out and in_stall only rises once all four stages are occupied
// while out_stall is high; a stalled result holds its value.
// reset clears the line parser, both duties and the switch state, and sets
// full_scale_duty to 4199. the apb port holds full_scale_duty at address 0
// and should be written only while no transaction is in flight.
module serial_motor_command_interlock (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  smci_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output smci_pkg::out_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smci_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [smci_pkg::FS_W-1:0]   full_scale_reg;
    smci_pkg::in_t               in_reg;
    logic                        v_in_reg, v_parse_reg, v_scale_reg, v_out_reg;
    logic                        rdy_in, rdy_parse, rdy_scale, rdy_out;
    logic                        cfg_write;
    logic                        cfg_hit;
    smci_pkg::parse_evt_t        parse_evt;
    smci_pkg::scale_evt_t        scale_evt;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[smci_pkg::APB_AW-1] == smci_pkg::REG_FULL_SCALE_SEL);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? {{(32 - smci_pkg::FS_W){1'b0}}, full_scale_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= smci_pkg::FS_RESET;
        end
        else if (cfg_write)
        begin
            full_scale_reg <= pwdata[smci_pkg::FS_W-1:0];
        end
    end

    // stage flow control
    assign rdy_out   = !v_out_reg || !out_stall;
    assign rdy_scale = !v_scale_reg || rdy_out;
    assign rdy_parse = !v_parse_reg || rdy_scale;
    assign rdy_in    = !v_in_reg || rdy_parse;
    assign in_stall  = !rdy_in;
    assign out_valid = v_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg    <= 1'b0;
            v_parse_reg <= 1'b0;
            v_scale_reg <= 1'b0;
            v_out_reg   <= 1'b0;
        end
        else
        begin
            if (rdy_in)
            begin
                v_in_reg <= in_valid;
            end
            if (rdy_parse)
            begin
                v_parse_reg <= v_in_reg;
            end
            if (rdy_scale)
            begin
                v_scale_reg <= v_parse_reg;
            end
            if (rdy_out)
            begin
                v_out_reg <= v_scale_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy_in)
        begin
            in_reg <= in_data;
        end
    end

    smci_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (v_in_reg && rdy_parse),
        .item       (in_reg),
        .full_scale (full_scale_reg),
        .evt        (parse_evt)
    );

    smci_scale u_scale (
        .clk     (clk),
        .load    (v_parse_reg && rdy_scale),
        .evt_in  (parse_evt),
        .evt_out (scale_evt)
    );

    smci_drive u_drive (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (v_scale_reg && rdy_out),
        .evt    (scale_evt),
        .result (out_data)
    );

endmodule

### bench/serial_motor_command_interlock_test.sv
// self-checking testbench for the serial motor command interlock
`timescale 1ns / 1ps

class interlock_scoreboard;
    localparam logic        ACT_BYTE     = 1'b0;
    localparam logic        ACT_SWITCH   = 1'b1;
    localparam int unsigned KEEP_LIMIT   = 63;   // characters kept per line
    localparam int unsigned MAG_CAP      = 101;
    localparam int unsigned PCT_MAX      = 100;
    localparam byte unsigned CHAR_NUL    = 8'h00;
    localparam byte unsigned CHAR_LF     = 8'h0A;
    localparam byte unsigned CHAR_CR     = 8'h0D;
    localparam byte unsigned CHAR_PLUS   = 8'h2B;
    localparam byte unsigned CHAR_COMMA  = 8'h2C;
    localparam byte unsigned CHAR_MINUS  = 8'h2D;
    localparam byte unsigned CHAR_ZERO   = 8'h30;
    localparam byte unsigned CHAR_NINE   = 8'h39;

    string             cmd_head = "$CMD,";
    smci_pkg::phase_t  phase;
    int unsigned       kept;
    int unsigned       mag_a;
    int unsigned       mag_b;
    bit                neg_a;
    bit                neg_b;
    logic [15:0]       duty_a;
    logic [15:0]       duty_b;
    logic [3:0]        contacts;
    int unsigned       full_scale;
    smci_pkg::out_t    pending_reports[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       samples;
    int unsigned       line_ends[4];

    function new();
        full_scale = 4199;
        duty_a = '0;
        duty_b = '0;
        contacts = '0;
        errors = 0;
        checked = 0;
        samples = 0;
        foreach (line_ends[i])
        begin
            line_ends[i] = 0;
        end
        clear_line();
    endfunction

    function void clear_line();
        phase = smci_pkg::PH_PRE0;
        kept = 0;
        mag_a = 0;
        mag_b = 0;
        neg_a = 1'b0;
        neg_b = 1'b0;
    endfunction

    function bit is_blank(byte unsigned c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function bit is_numeral(byte unsigned c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function int unsigned accumulate(int unsigned m, byte unsigned c);
        int unsigned v;
        v = m * 10 + (c - CHAR_ZERO);
        return (v > MAG_CAP) ? MAG_CAP : v;
    endfunction

    function void begin_number(byte unsigned c, bit second);
        if (second)
        begin
            mag_b = c - CHAR_ZERO;
            phase = smci_pkg::PH_B_DIG;
        end
        else
        begin
            mag_a = c - CHAR_ZERO;
            phase = smci_pkg::PH_A_DIG;
        end
    endfunction

    function void parse_char(byte unsigned c);
        bit second;
        second = (phase == smci_pkg::PH_B_WS || phase == smci_pkg::PH_B_SIGN);
        // nul closes the parsable part of the line
        if (c == CHAR_NUL)
        begin
            if (phase == smci_pkg::PH_B_DIG || phase == smci_pkg::PH_DONE)
                phase = smci_pkg::PH_DONE;
            else
                phase = smci_pkg::PH_FAIL;
            return;
        end
        case (phase)
            smci_pkg::PH_PRE0, smci_pkg::PH_PRE1, smci_pkg::PH_PRE2,
            smci_pkg::PH_PRE3, smci_pkg::PH_PRE4:
            begin
                if (c == cmd_head[int'(phase)])
                    phase = smci_pkg::phase_t'(phase + 4'd1);
                else
                    phase = smci_pkg::PH_FAIL;
            end
            smci_pkg::PH_A_WS, smci_pkg::PH_B_WS:
            begin
                if (!is_blank(c))
                begin
                    if (c == CHAR_PLUS || c == CHAR_MINUS)
                    begin
                        if (c == CHAR_MINUS)
                        begin
                            if (second)
                                neg_b = 1'b1;
                            else
                                neg_a = 1'b1;
                        end
                        if (second)
                            phase = smci_pkg::PH_B_SIGN;
                        else
                            phase = smci_pkg::PH_A_SIGN;
                    end
                    else if (is_numeral(c))
                        begin_number(c, second);
                    else
                        phase = smci_pkg::PH_FAIL;
                end
            end
            smci_pkg::PH_A_SIGN, smci_pkg::PH_B_SIGN:
            begin
                if (is_numeral(c))
                    begin_number(c, second);
                else
                    phase = smci_pkg::PH_FAIL;
            end
            smci_pkg::PH_A_DIG:
            begin
                if (is_numeral(c))
                    mag_a = accumulate(mag_a, c);
                else if (c == CHAR_COMMA)
                    phase = smci_pkg::PH_B_WS;
                else
                    phase = smci_pkg::PH_FAIL;
            end
            smci_pkg::PH_B_DIG:
            begin
                if (is_numeral(c))
                    mag_b = accumulate(mag_b, c);
                else
                    phase = smci_pkg::PH_DONE;
            end
            smci_pkg::PH_DONE:
                phase = smci_pkg::PH_DONE;
            default:
                phase = smci_pkg::PH_FAIL;
        endcase
    endfunction

    function logic [15:0] scale(int unsigned mag, bit neg);
        int unsigned m;
        logic [31:0] d;
        m = (mag > PCT_MAX) ? PCT_MAX : mag;
        d = m * full_scale / PCT_MAX;
        if (neg)
            d = -d;
        return d[15:0];
    endfunction

    function smci_pkg::status_t finish_line();
        smci_pkg::status_t st;
        if (phase == smci_pkg::PH_B_DIG || phase == smci_pkg::PH_DONE)
        begin
            if (contacts != 0)
                st = smci_pkg::ST_REFUSED;
            else
            begin
                duty_a = scale(mag_a, neg_a);
                duty_b = scale(mag_b, neg_b);
                st = smci_pkg::ST_APPLIED;
            end
        end
        else
            st = smci_pkg::ST_MALFORMED;
        clear_line();
        return st;
    endfunction

    function smci_pkg::out_t next_report(smci_pkg::in_t t);
        smci_pkg::out_t    r;
        smci_pkg::status_t st;
        st = smci_pkg::ST_NONE;
        if (t.action == ACT_SWITCH)
        begin
            samples++;
            contacts = t.switch_bits;
            if (contacts != 0)
            begin
                duty_a = '0;
                duty_b = '0;
            end
        end
        else if (t.rx_char == CHAR_LF)
        begin
            st = finish_line();
            line_ends[st]++;
        end
        else if (t.rx_char != CHAR_CR && kept < KEEP_LIMIT)
        begin
            kept++;
            parse_char(t.rx_char);
        end
        r.drive_a = duty_a;
        r.drive_b = duty_b;
        r.contact_bits = contacts;
        r.docked = (contacts != 0);
        r.line_status = st;
        return r;
    endfunction

    function void note_command(smci_pkg::in_t t);
        pending_reports.push_back(next_report(t));
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_report(smci_pkg::out_t got);
        smci_pkg::out_t want;
        if (pending_reports.size() == 0)
        begin
            $error("result transaction with no command waiting: %h", got);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        checked++;
        compare("drive_a", want.drive_a, got.drive_a);
        compare("drive_b", want.drive_b, got.drive_b);
        compare("contact_bits", want.contact_bits, got.contact_bits);
        compare("docked", want.docked, got.docked);
        compare("line_status", want.line_status, got.line_status);
    endfunction
endclass

module serial_motor_command_interlock_test;
    localparam int unsigned CYCLE_LIMIT    = 100000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned CHUNK_ITEMS    = 40;
    localparam int unsigned CHUNKS         = 6;
    localparam int          REG_FULL_SCALE = 0;
    localparam logic        ACT_BYTE       = 1'b0;
    localparam logic        ACT_SWITCH     = 1'b1;
    localparam logic [smci_pkg::APB_AW-1:0] FULL_SCALE_ADDR =
        smci_pkg::APB_AW'(4 * REG_FULL_SCALE);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    smci_pkg::in_t  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    smci_pkg::out_t out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [smci_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    interlock_scoreboard board;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    byte unsigned line_buf[$];
    string       blank_set = " \t\v\f";

    serial_motor_command_interlock i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // outputs only move at the rising edge, so the falling edge sees what the next edge takes
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_report(out_data);
    end

    task automatic send_item(smci_pkg::in_t item);
        logic [$bits(smci_pkg::in_t)-1:0] noise;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            noise = $bits(smci_pkg::in_t)'($urandom);
            in_valid <= 1'b0;
            in_data <= noise;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(negedge clk);
        while (in_stall);
        board.note_command(item);
        items_sent++;
        @(posedge clk);
    endtask

    task automatic send_byte(byte unsigned c);
        smci_pkg::in_t t;
        t.action = ACT_BYTE;
        t.rx_char = c;
        t.switch_bits = 4'($urandom);
        send_item(t);
    endtask

    task automatic send_switch(logic [3:0] bits);
        smci_pkg::in_t t;
        t.action = ACT_SWITCH;
        t.rx_char = 8'($urandom);
        t.switch_bits = bits;
        send_item(t);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_full_scale(int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= FULL_SCALE_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.full_scale = value & 32'h7FFF;
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void push_blanks(int unsigned n);
        repeat (n) line_buf.push_back(blank_set[$urandom_range(0, 3)]);
    endfunction

    function automatic void push_number();
        int unsigned sign_pick;
        string       digits;
        if ($urandom_range(0, 3) == 0)
            push_blanks($urandom_range(1, 3));
        sign_pick = $urandom_range(0, 2);
        if (sign_pick == 1)
            line_buf.push_back(smci_pkg::CH_PLUS);
        else if (sign_pick == 2)
            line_buf.push_back(smci_pkg::CH_MINUS);
        // mostly in range, sometimes far beyond to hit saturation
        if ($urandom_range(0, 3) == 0)
            digits = $sformatf("%0d", $urandom_range(0, 999999));
        else
            digits = $sformatf("%0d", $urandom_range(0, 100));
        if ($urandom_range(0, 7) == 0)
            digits = {"0", digits};
        push_text(digits);
    endfunction

    function automatic void build_command(int unsigned pad);
        push_text("$CMD,");
        push_blanks(pad);
        push_number();
        line_buf.push_back(smci_pkg::CH_COMMA);
        push_number();
        if ($urandom_range(0, 9) == 0)
        begin
            line_buf.push_back(smci_pkg::CH_NUL);
            repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else if ($urandom_range(0, 4) == 0)
            push_text(" go");
        if ($urandom_range(0, 4) == 0)
            line_buf.insert($urandom_range(0, line_buf.size()), smci_pkg::CH_CR);
        line_buf.push_back(smci_pkg::CH_LF);
    endfunction

    task automatic run_directed();
        send_switch(4'h0);
        send_text("$CMD,100,-100\n");
        send_text("$CMD,+55,-0\n");
        send_text("$CMD, \t\v\f-7,\t +33 trailing text\n");
        send_text("$CMD,99999,-123456789\n");
        send_text("$CMD,\r-5,\r6\r\n");
        send_text("$CMD,12,34");
        send_byte(smci_pkg::CH_NUL);
        send_text("9\n");
        send_text("$CMD,12");
        send_byte(smci_pkg::CH_NUL);
        send_text(",3\n");
        send_text("\n");
        send_text("$cmd,1,2\n");
        send_text("$CMD,1 ,2\n");
        send_text("$CMD,-,5\n");
        send_text("$CMD,5,\n");
        send_text("$CMD,");
        send_byte(8'hFF);
        send_text("1,1\n");
        // padding that just fits, then one blank too many so the digit is cut off
        send_text("$CMD,7,");
        repeat (55) send_byte(" ");
        send_text("9\n");
        send_text("$CMD,8,");
        repeat (56) send_byte(" ");
        send_text("9\n");
        send_switch(4'hF);
        send_text("$CMD,10,10\n");
        send_switch(4'h1);
        send_switch(4'h8);
        send_text("$CMD,-3,4\n");
        send_switch(4'h0);
        send_text("$CMD,-100,100\n");
    endtask

    task automatic run_random(int unsigned quota);
        int unsigned start;
        int unsigned kind;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            kind = $urandom_range(0, 99);
            line_buf.delete();
            if (kind < 60)
                build_command(0);
            else if (kind < 72)
            begin
                build_command(0);
                line_buf[$urandom_range(0, line_buf.size() - 2)] = 8'($urandom_range(0, 255));
            end
            else if (kind < 82)
            begin
                repeat ($urandom_range(0, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1)
                    line_buf.push_back(smci_pkg::CH_LF);
            end
            else if (kind < 87)
                build_command($urandom_range(45, 70));
            if (kind >= 87)
                send_switch(($urandom_range(0, 1) == 1) ? 4'($urandom_range(1, 15)) : 4'h0);
            else
                send_line_buf();
        end
    endtask

    initial
    begin
        int unsigned full_scale_plan[CHUNKS];
        board = new();
        full_scale_plan = '{32767, 1, 0, 4199, 100, 1000};
        full_scale_plan[3] = $urandom_range(2, 32766);
        full_scale_plan[5] = $urandom_range(1, 32767);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 21;
        recv_stall_pct = 54;
        run_directed();
        settle();
        for (int k = 0; k < CHUNKS; k++)
        begin
            if (k < 2)
            begin
                send_idle_pct = 21;
                recv_stall_pct = 54;
            end
            else if (k < 4)
            begin
                send_idle_pct = 54;
                recv_stall_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_full_scale(full_scale_plan[k]);
            run_random(CHUNK_ITEMS);
            settle();
        end
        $display("run covered %0d transactions, %0d of them switch samples",
                 board.checked, board.samples);
        $display("line ends applied %0d, refused %0d, malformed %0d over six full scale values",
                 board.line_ends[smci_pkg::ST_APPLIED], board.line_ends[smci_pkg::ST_REFUSED],
                 board.line_ends[smci_pkg::ST_MALFORMED]);
        if (board.errors == 0 && board.pending_reports.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

### serial_motor_command_interlock.f
rtl/smci_pkg.sv
rtl/smci_parser.sv
rtl/smci_scale.sv
rtl/smci_drive.sv
rtl/serial_motor_command_interlock.sv
bench/serial_motor_command_interlock_test.sv
